>>> rtl/ppw_pkg.sv
package ppw_pkg;

   localparam int MAX_POINTS = 256;
   localparam int ADDR_W     = 8;
   localparam int COORD_W    = 24;
   localparam int HEAD_W     = 16;
   localparam int LEN_W      = 24;
   localparam int DIVD_W     = 48;
   localparam int DIVS_W     = 33;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [HEAD_W-1:0]         h;
      logic [LEN_W-1:0]          len;
   } point_type;

endpackage

>>> rtl/ppw_mem.sv
module ppw_mem (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ppw_pkg::ADDR_W-1:0]   wr_addr,
   input  ppw_pkg::point_type           wr_data,
   input  logic [ppw_pkg::ADDR_W-1:0]   rd_addr,
   output ppw_pkg::point_type           rd_data
);

   ppw_pkg::point_type mem_ff [ppw_pkg::MAX_POINTS];
   ppw_pkg::point_type q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      q_ff <= mem_ff[rd_addr];
   end

   assign rd_data = q_ff;

endmodule

>>> rtl/ppw_div.sv
module ppw_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ppw_pkg::DIVD_W-1:0]  dividend,
   input  logic [ppw_pkg::DIVS_W-1:0]  divisor,
   output logic                        done,
   output logic [ppw_pkg::DIVD_W-1:0]  quotient,
   output logic [ppw_pkg::DIVS_W-1:0]  remainder
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [ppw_pkg::DIVD_W-1:0] quo_ff, quo_in;
   logic [ppw_pkg::DIVS_W-1:0] rem_ff, rem_in;
   logic [ppw_pkg::DIVS_W-1:0] dvs_ff, dvs_in;
   logic [5:0]                 cnt_ff, cnt_in;
   logic [ppw_pkg::DIVS_W:0]   trial;
   logic [ppw_pkg::DIVS_W:0]   diff;
   logic                       ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[ppw_pkg::DIVD_W-1]};
      ge      = trial >= {1'b0, dvs_ff};
      diff    = trial - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[ppw_pkg::DIVS_W-1:0] : trial[ppw_pkg::DIVS_W-1:0];
         quo_in = {quo_ff[ppw_pkg::DIVD_W-2:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(ppw_pkg::DIVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/polyline_path_walker.sv
// A load writes one table entry and gives no word; begin and end give a word after a table read.
// A move walks the segments that it crosses and then interpolates with a divide, plus a lap
// sum and a lap reduction by divide when loop_mode is set.
// Throughput: one item at a time; the segment walk and the serial divider set the rate.
// Reset (synchronous): cursor (0, 0), loop_mode 0, point_count 2; table contents undefined.
module polyline_path_walker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_mode,
   input  logic [7:0]          req_point_index,
   input  logic signed [23:0]  req_point_x,
   input  logic signed [23:0]  req_point_y,
   input  logic [15:0]         req_point_heading,
   input  logic [23:0]         req_point_length,
   input  logic [23:0]         req_move_distance,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [23:0]  rsp_pos_x,
   output logic signed [23:0]  rsp_pos_y,
   output logic [15:0]         rsp_heading,
   output logic                rsp_at_end,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [0:0]          csr_index,
   input  logic [8:0]          csr_data
);

   localparam logic [2:0] MODE_LOAD  = 3'd0;
   localparam logic [2:0] MODE_FWD   = 3'd1;
   localparam logic [2:0] MODE_BACK  = 3'd2;
   localparam logic [2:0] MODE_BEGIN = 3'd3;
   localparam logic [2:0] MODE_END   = 3'd4;

   localparam logic [0:0] REG_LOOP  = 1'd0;
   localparam logic [0:0] REG_COUNT = 1'd1;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CLAMP = 4'd1;
   localparam logic [3:0] ST_SUM   = 4'd2;
   localparam logic [3:0] ST_WF    = 4'd3;
   localparam logic [3:0] ST_WFLEN = 4'd4;
   localparam logic [3:0] ST_WB    = 4'd5;
   localparam logic [3:0] ST_WBLEN = 4'd6;
   localparam logic [3:0] ST_MOD   = 4'd7;
   localparam logic [3:0] ST_PT    = 4'd8;
   localparam logic [3:0] ST_FSTOP = 4'd9;
   localparam logic [3:0] ST_I1    = 4'd10;
   localparam logic [3:0] ST_I2    = 4'd11;
   localparam logic [3:0] ST_I3    = 4'd12;
   localparam logic [3:0] ST_I4    = 4'd13;
   localparam logic [3:0] ST_IDIV  = 4'd14;
   localparam logic [3:0] ST_OUT   = 4'd15;

   logic [3:0]          state_ff, state_in;
   logic [7:0]          seg_ff, seg_in;
   logic [23:0]         off_ff, off_in;
   logic                loop_ff, loop_in;
   logic [8:0]          cnt_ff, cnt_in;
   logic [2:0]          mode_ff, mode_in;
   logic [7:0]          i_ff, i_in;
   logic [23:0]         d_ff, d_in;
   logic [23:0]         tot_ff, tot_in;
   logic [32:0]         lap_ff, lap_in;
   logic [8:0]          k_ff, k_in;
   logic                pend_ff, pend_in;
   logic [23:0]         len_ff, len_in;
   logic signed [23:0]  ax_ff, ax_in;
   logic signed [23:0]  ay_ff, ay_in;
   logic [15:0]         h_ff, h_in;
   logic [23:0]         alen_ff, alen_in;
   logic signed [24:0]  dx_ff, dx_in;
   logic signed [24:0]  dy_ff, dy_in;
   logic signed [48:0]  px_ff, px_in;
   logic signed [48:0]  py_ff, py_in;
   logic                pend_end_ff, pend_end_in;
   logic                setoff_ff, setoff_in;
   logic                keeph_ff, keeph_in;
   logic signed [23:0]  res_x_ff, res_x_in;
   logic signed [23:0]  res_y_ff, res_y_in;
   logic [15:0]         res_h_ff, res_h_in;
   logic                res_end_ff, res_end_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [23:0]  rsp_x_ff, rsp_x_in;
   logic signed [23:0]  rsp_y_ff, rsp_y_in;
   logic [15:0]         rsp_h_ff, rsp_h_in;
   logic                rsp_end_ff, rsp_end_in;

   logic [8:0]          n_w;
   logic [8:0]          nm1_w;
   logic [8:0]          nm2_w;
   logic                req_acc;
   logic                mem_wr;
   logic [7:0]          rd_addr;
   ppw_pkg::point_type  wr_pt;
   ppw_pkg::point_type  q;

   logic                divx_start, divy_start;
   logic [47:0]         divx_dvd, divy_dvd;
   logic [32:0]         divx_dvs, divy_dvs;
   logic                divx_done, divy_done;
   logic [47:0]         divx_quo, divy_quo;
   logic [32:0]         divx_rem, divy_rem;

   logic [23:0]         left_w;
   logic [23:0]         t2_w;
   logic [7:0]          inext_w;
   logic [7:0]          iprev_w;
   logic [48:0]         pxmag_w, pymag_w;
   logic [23:0]         qx_w, qy_w;

   ppw_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (req_point_index),
      .wr_data (wr_pt),
      .rd_addr (rd_addr),
      .rd_data (q)
   );

   ppw_div u_divx (
      .clock     (clock),
      .reset     (reset),
      .start     (divx_start),
      .dividend  (divx_dvd),
      .divisor   (divx_dvs),
      .done      (divx_done),
      .quotient  (divx_quo),
      .remainder (divx_rem)
   );

   ppw_div u_divy (
      .clock     (clock),
      .reset     (reset),
      .start     (divy_start),
      .dividend  (divy_dvd),
      .divisor   (divy_dvs),
      .done      (divy_done),
      .quotient  (divy_quo),
      .remainder (divy_rem)
   );

   assign n_w   = (cnt_ff < 9'd2) ? 9'd2 :
                  (cnt_ff > 9'(ppw_pkg::MAX_POINTS)) ? 9'(ppw_pkg::MAX_POINTS) : cnt_ff;
   assign nm1_w = n_w - 9'd1;
   assign nm2_w = n_w - 9'd2;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign mem_wr    = req_acc && (req_mode == MODE_LOAD);

   assign wr_pt.x   = req_point_x;
   assign wr_pt.y   = req_point_y;
   assign wr_pt.h   = req_point_heading;
   assign wr_pt.len = req_point_length;

   assign left_w  = len_ff - d_ff;
   assign t2_w    = tot_ff - left_w;
   assign inext_w = (i_ff == nm1_w[7:0]) ? 8'd0 : i_ff + 8'd1;
   assign iprev_w = (i_ff == 8'd0) ? nm1_w[7:0] : i_ff - 8'd1;
   assign pxmag_w = px_ff[48] ? -px_ff : px_ff;
   assign pymag_w = py_ff[48] ? -py_ff : py_ff;
   assign qx_w    = px_ff[48] ? -divx_quo[23:0] : divx_quo[23:0];
   assign qy_w    = py_ff[48] ? -divy_quo[23:0] : divy_quo[23:0];

   always_comb begin
      state_in    = state_ff;
      seg_in      = seg_ff;
      off_in      = off_ff;
      loop_in     = loop_ff;
      cnt_in      = cnt_ff;
      mode_in     = mode_ff;
      i_in        = i_ff;
      d_in        = d_ff;
      tot_in      = tot_ff;
      lap_in      = lap_ff;
      k_in        = k_ff;
      pend_in     = 1'b0;
      len_in      = len_ff;
      ax_in       = ax_ff;
      ay_in       = ay_ff;
      h_in        = h_ff;
      alen_in     = alen_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      pend_end_in = pend_end_ff;
      setoff_in   = setoff_ff;
      keeph_in    = keeph_ff;
      res_x_in    = res_x_ff;
      res_y_in    = res_y_ff;
      res_h_in    = res_h_ff;
      res_end_in  = res_end_ff;
      rsp_x_in    = rsp_x_ff;
      rsp_y_in    = rsp_y_ff;
      rsp_h_in    = rsp_h_ff;
      rsp_end_in  = rsp_end_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_addr     = i_ff;
      divx_start  = 1'b0;
      divy_start  = 1'b0;
      divx_dvd    = pxmag_w[47:0];
      divx_dvs    = {9'd0, alen_ff};
      divy_dvd    = pymag_w[47:0];
      divy_dvs    = {9'd0, alen_ff};

      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_LOOP:  loop_in = csr_data[0];
            REG_COUNT: cnt_in  = csr_data;
            default:   ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            rd_addr = ({1'b0, seg_ff} >= n_w) ? nm1_w[7:0] : seg_ff;
            if (req_acc && req_mode != MODE_LOAD && req_mode <= MODE_END) begin
               mode_in  = req_mode;
               tot_in   = req_move_distance;
               i_in     = rd_addr;
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            len_in = q.len;
            d_in   = (off_ff > q.len) ? q.len : off_ff;
            pend_end_in = 1'b0;
            keeph_in    = 1'b0;
            setoff_in   = 1'b0;
            if (mode_ff == MODE_BEGIN) begin
               seg_in   = 8'd0;
               off_in   = 24'd0;
               rd_addr  = 8'd0;
               state_in = ST_PT;
            end else if (mode_ff == MODE_END) begin
               seg_in    = nm1_w[7:0];
               setoff_in = 1'b1;
               rd_addr   = nm1_w[7:0];
               state_in  = ST_PT;
            end else if (loop_ff) begin
               k_in     = 9'd0;
               lap_in   = 33'd0;
               state_in = ST_SUM;
            end else begin
               state_in = (mode_ff == MODE_FWD) ? ST_WF : ST_WB;
            end
         end
         ST_SUM: begin
            rd_addr = k_ff[7:0];
            if (k_ff < n_w) begin
               k_in    = k_ff + 9'd1;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               lap_in = lap_ff + {9'd0, q.len};
            end
            if (k_ff == n_w && !pend_ff) begin
               if (lap_ff == 33'd0) begin
                  seg_in   = i_ff;
                  off_in   = d_ff;
                  rd_addr  = i_ff;
                  state_in = ST_I1;
               end else begin
                  state_in = (mode_ff == MODE_FWD) ? ST_WF : ST_WB;
               end
            end
         end
         ST_WF: begin
            if (tot_ff < left_w) begin
               d_in     = d_ff + tot_ff;
               seg_in   = i_ff;
               off_in   = d_ff + tot_ff;
               rd_addr  = i_ff;
               state_in = ST_I1;
            end else begin
               tot_in = t2_w;
               d_in   = 24'd0;
               if (loop_ff) begin
                  i_in = inext_w;
                  if ({9'd0, t2_w} >= lap_ff) begin
                     divx_start = 1'b1;
                     divx_dvd   = {24'd0, t2_w};
                     divx_dvs   = lap_ff;
                     state_in   = ST_MOD;
                  end else begin
                     rd_addr  = inext_w;
                     state_in = ST_WFLEN;
                  end
               end else if ({2'b0, i_ff} + 10'd2 < {1'b0, n_w}) begin
                  i_in     = i_ff + 8'd1;
                  rd_addr  = i_ff + 8'd1;
                  state_in = ST_WFLEN;
               end else begin
                  rd_addr  = nm2_w[7:0];
                  state_in = ST_FSTOP;
               end
            end
         end
         ST_WFLEN: begin
            len_in   = q.len;
            state_in = ST_WF;
         end
         ST_WB: begin
            if (tot_ff < d_ff) begin
               d_in     = d_ff - tot_ff;
               seg_in   = i_ff;
               off_in   = d_ff - tot_ff;
               rd_addr  = i_ff;
               state_in = ST_I1;
            end else begin
               tot_in = tot_ff - d_ff;
               if (loop_ff) begin
                  i_in     = iprev_w;
                  rd_addr  = iprev_w;
                  state_in = ST_WBLEN;
               end else if (i_ff == 8'd0) begin
                  seg_in      = 8'd0;
                  off_in      = 24'd0;
                  rd_addr     = 8'd0;
                  pend_end_in = 1'b1;
                  state_in    = ST_PT;
               end else begin
                  i_in     = i_ff - 8'd1;
                  rd_addr  = i_ff - 8'd1;
                  state_in = ST_WBLEN;
               end
            end
         end
         ST_WBLEN: begin
            d_in = q.len;
            if (loop_ff && {9'd0, tot_ff} >= lap_ff) begin
               divx_start = 1'b1;
               divx_dvd   = {24'd0, tot_ff};
               divx_dvs   = lap_ff;
               state_in   = ST_MOD;
            end else begin
               state_in = ST_WB;
            end
         end
         ST_MOD: begin
            if (divx_done) begin
               tot_in = divx_rem[23:0];
               if (mode_ff == MODE_FWD) begin
                  rd_addr  = i_ff;
                  state_in = ST_WFLEN;
               end else begin
                  state_in = ST_WB;
               end
            end
         end
         ST_FSTOP: begin
            seg_in      = nm2_w[7:0];
            off_in      = q.len;
            h_in        = q.h;
            keeph_in    = 1'b1;
            pend_end_in = 1'b1;
            rd_addr     = nm1_w[7:0];
            state_in    = ST_PT;
         end
         ST_PT: begin
            res_x_in   = q.x;
            res_y_in   = q.y;
            res_h_in   = keeph_ff ? h_ff : q.h;
            res_end_in = pend_end_ff;
            if (setoff_ff) begin
               off_in = q.len;
            end
            state_in = ST_OUT;
         end
         ST_I1: begin
            ax_in    = q.x;
            ay_in    = q.y;
            h_in     = q.h;
            alen_in  = q.len;
            rd_addr  = inext_w;
            state_in = ST_I2;
         end
         ST_I2: begin
            dx_in    = {q.x[23], q.x} - {ax_ff[23], ax_ff};
            dy_in    = {q.y[23], q.y} - {ay_ff[23], ay_ff};
            state_in = ST_I3;
         end
         ST_I3: begin
            px_in    = 49'(dx_ff) * 49'($signed({1'b0, d_ff}));
            py_in    = 49'(dy_ff) * 49'($signed({1'b0, d_ff}));
            state_in = ST_I4;
         end
         ST_I4: begin
            res_h_in   = h_ff;
            res_end_in = 1'b0;
            if (alen_ff == 24'd0) begin
               res_x_in = ax_ff;
               res_y_in = ay_ff;
               state_in = ST_OUT;
            end else begin
               divx_start = 1'b1;
               divy_start = 1'b1;
               state_in   = ST_IDIV;
            end
         end
         ST_IDIV: begin
            if (divx_done) begin
               res_x_in = ax_ff + qx_w;
               res_y_in = ay_ff + qy_w;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = res_x_ff;
               rsp_y_in     = res_y_ff;
               rsp_h_in     = res_h_ff;
               rsp_end_in   = res_end_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seg_ff       <= 8'd0;
         off_ff       <= 24'd0;
         loop_ff      <= 1'b0;
         cnt_ff       <= 9'd2;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_ff       <= seg_in;
         off_ff       <= off_in;
         loop_ff      <= loop_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      i_ff        <= i_in;
      d_ff        <= d_in;
      tot_ff      <= tot_in;
      lap_ff      <= lap_in;
      k_ff        <= k_in;
      len_ff      <= len_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      h_ff        <= h_in;
      alen_ff     <= alen_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      pend_end_ff <= pend_end_in;
      setoff_ff   <= setoff_in;
      keeph_ff    <= keeph_in;
      res_x_ff    <= res_x_in;
      res_y_ff    <= res_y_in;
      res_h_ff    <= res_h_in;
      res_end_ff  <= res_end_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_h_ff    <= rsp_h_in;
      rsp_end_ff  <= rsp_end_in;
   end

   // y divider remainder is never needed
   logic unused_rem;
   assign unused_rem = ^divy_rem ^ divy_done ^ ^divx_quo[47:24] ^ ^divy_quo[47:24];

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = rsp_x_ff;
   assign rsp_pos_y   = rsp_y_ff;
   assign rsp_heading = rsp_h_ff;
   assign rsp_at_end  = rsp_end_ff;

endmodule
